FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a clock with active-low reset
`define BLP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define BLP_NEVER(label, clk, rst_n, cond, msg) \
	`BLP_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: sv/blp_pkg.sv
`timescale 1ns / 1ps

package blp_pkg;

	localparam int PW = 32;

	localparam logic [1:0] KIND_CALL_EU = 2'd0;
	localparam logic [1:0] KIND_PUT_EU  = 2'd1;
	localparam logic [1:0] KIND_PUT_AM  = 2'd2;

	typedef enum logic [2:0] {
		REG_KIND  = 3'd0,
		REG_STEPS = 3'd1,
		REG_UP    = 3'd2,
		REG_DOWN  = 3'd3,
		REG_PROB  = 3'd4,
		REG_DISC  = 3'd5
	} cfg_reg_t;

	localparam logic [8:0]    RST_STEPS = 9'd1;
	localparam logic [PW-1:0] RST_UP    = 32'h4000_0000;
	localparam logic [PW-1:0] RST_DOWN  = 32'h4000_0000;
	localparam logic [PW-1:0] RST_PROB  = 32'h8000_0000;
	localparam logic [PW-1:0] RST_DISC  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]    kind;
		logic [8:0]    steps;
		logic [PW-1:0] up;
		logic [PW-1:0] down;
		logic [PW-1:0] prob;
		logic [PW-1:0] disc;
	} cfg_t;

	typedef struct packed {
		logic          go;
		logic [PW-1:0] x;
		logic [PW-1:0] f;
		logic          sh30;
	} sc_req_t;

	typedef struct packed {
		logic          done;
		logic [PW-1:0] y;
		logic          ovf;
	} sc_rsp_t;

endpackage

FILE: sv/binomial_lattice_option_pricer_top.sv
// channel | signals                                 | direction
// cfg     | cfg_valid cfg_ready cfg_index cfg_data  | write request in
// in      | in_valid in_ready spot_price strike_price | request in
// out     | out_valid out_ready option_value saturated | result out
//
// One request's run time grows with the step count n and is set by the multiply-round
// unit, which has one op in flight at a time: each lattice price built and each value
// folded back waits for that unit's result.
// Reset clears the handshake state and loads the register defaults; no clearing pass.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binomial_lattice_option_pricer_top import blp_pkg::*; #(
	parameter int MAX_STEPS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [PW-1:0] cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [PW-1:0] spot_price,
	input  logic [PW-1:0] strike_price,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [PW-1:0] option_value,
	output logic          saturated
);

	localparam int IW    = $clog2(MAX_STEPS + 1);
	localparam int NODES = (MAX_STEPS + 1) * (MAX_STEPS + 2) / 2;
	localparam int PAW   = $clog2(NODES);

	cfg_t           cfg_q;
	logic           vm_we, pm_we;
	logic [IW-1:0]  vm_waddr, vm_raddr;
	logic [PAW-1:0] pm_waddr, pm_raddr;
	logic [PW-1:0]  vm_wdata, vm_rdata, pm_wdata, pm_rdata;
	sc_req_t        sc_req;
	sc_rsp_t        sc_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind  <= KIND_CALL_EU;
			cfg_q.steps <= RST_STEPS;
			cfg_q.up    <= RST_UP;
			cfg_q.down  <= RST_DOWN;
			cfg_q.prob  <= RST_PROB;
			cfg_q.disc  <= RST_DISC;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KIND:  cfg_q.kind  <= cfg_data[1:0];
				REG_STEPS: cfg_q.steps <= cfg_data[8:0];
				REG_UP:    cfg_q.up    <= cfg_data;
				REG_DOWN:  cfg_q.down  <= cfg_data;
				REG_PROB:  cfg_q.prob  <= cfg_data;
				REG_DISC:  cfg_q.disc  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	blp_ram #(.WIDTH(PW), .DEPTH(MAX_STEPS + 1)) u_values (
		.clk   (clk),
		.we    (vm_we),
		.waddr (vm_waddr),
		.wdata (vm_wdata),
		.raddr (vm_raddr),
		.rdata (vm_rdata)
	);

	blp_ram #(.WIDTH(PW), .DEPTH(NODES)) u_prices (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (pm_wdata),
		.raddr (pm_raddr),
		.rdata (pm_rdata)
	);

	blp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sc_req),
		.rsp    (sc_rsp)
	);

	blp_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.spot_price   (spot_price),
		.strike_price (strike_price),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.option_value (option_value),
		.saturated    (saturated),
		.vm_we        (vm_we),
		.vm_waddr     (vm_waddr),
		.vm_wdata     (vm_wdata),
		.vm_raddr     (vm_raddr),
		.vm_rdata     (vm_rdata),
		.pm_we        (pm_we),
		.pm_waddr     (pm_waddr),
		.pm_wdata     (pm_wdata),
		.pm_raddr     (pm_raddr),
		.pm_rdata     (pm_rdata),
		.sc_req       (sc_req),
		.sc_rsp       (sc_rsp)
	);

	`BLP_ASSERT(a_busy_after_req, clk, arst_n, in_valid && in_ready |=> !in_ready, "ready after request")
	`BLP_ASSERT(a_scale_latency, clk, arst_n, sc_rsp.done |-> $past(sc_req.go, 2), "stray scale result")
	`BLP_ASSERT(a_idle_on_result, clk, arst_n, $rose(out_valid) |-> in_ready, "result while busy")
	`BLP_NEVER(a_no_dual_write, clk, arst_n, vm_we && pm_we, "both memories written")

endmodule

FILE: sv/blp_ram.sv
`timescale 1ns / 1ps

module blp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/blp_scale.sv
`timescale 1ns / 1ps

module blp_scale import blp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  sc_req_t req,
	output sc_rsp_t rsp
);

	localparam logic [2*PW-1:0] RND30 = 64'h0000_0000_2000_0000;
	localparam logic [2*PW-1:0] RND32 = 64'h0000_0000_8000_0000;

	logic            vld_s1, vld_s2;
	logic            sh30_s1;
	logic [2*PW-1:0] prod_s1;
	logic [PW-1:0]   y_s2;
	logic            ovf_s2;
	logic [2*PW-1:0] sum;
	logic [PW+1:0]   shf;
	logic            ovf;

	always_comb begin
		sum = prod_s1 + (sh30_s1 ? RND30 : RND32);
		shf = sh30_s1 ? sum[2*PW-1:30] : {2'b00, sum[2*PW-1:32]};
		ovf = |shf[PW+1:PW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.go;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(req.x) * 64'(req.f);
		sh30_s1 <= req.sh30;
		y_s2    <= ovf ? '1 : shf[PW-1:0];
		ovf_s2  <= ovf;
	end

	assign rsp.done = vld_s2;
	assign rsp.y    = y_s2;
	assign rsp.ovf  = ovf_s2;

endmodule

FILE: sv/blp_ctrl.sv
`timescale 1ns / 1ps

module blp_ctrl import blp_pkg::*; #(
	parameter int MAX_STEPS = 256,
	localparam int IW = $clog2(MAX_STEPS + 1),
	localparam int NODES = (MAX_STEPS + 1) * (MAX_STEPS + 2) / 2,
	localparam int PAW = $clog2(NODES)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cfg_t           cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [PW-1:0]  spot_price,
	input  logic [PW-1:0]  strike_price,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [PW-1:0]  option_value,
	output logic           saturated,
	output logic           vm_we,
	output logic [IW-1:0]  vm_waddr,
	output logic [PW-1:0]  vm_wdata,
	output logic [IW-1:0]  vm_raddr,
	input  logic [PW-1:0]  vm_rdata,
	output logic           pm_we,
	output logic [PAW-1:0] pm_waddr,
	output logic [PW-1:0]  pm_wdata,
	output logic [PAW-1:0] pm_raddr,
	input  logic [PW-1:0]  pm_rdata,
	output sc_req_t        sc_req,
	input  sc_rsp_t        sc_rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_BFIRST, S_BNEXT, S_BWAIT, S_TRD, S_TWR,
		S_ILVL, S_IRD0, S_IRD1, S_IW1, S_IW2, S_IW3, S_FIN
	} state_t;

	function automatic logic [PW-1:0] payoff(input logic put, input logic [PW-1:0] price,
			input logic [PW-1:0] strike);
		if (put) begin
			return (strike > price) ? strike - price : '0;
		end
		return (price > strike) ? price - strike : '0;
	endfunction

	state_t         state_q;
	logic [PW-1:0]  spot_q, strike_q, cur_q, head_q;
	logic [PW-1:0]  vu_q, vd_q, ep_q, su_q, res_q;
	logic [IW-1:0]  n_q, a_q, b_q, i_q, lvl_q;
	logic [PAW-1:0] col_q, addr_q;
	logic           put_q, amer_q, colst_q, sat_q;
	logic           out_valid_q, saturated_q;
	logic [PW-1:0]  option_value_q;

	logic [IW-1:0]  n_eff;
	logic [PW:0]    add_sum;
	logic [PW-1:0]  t_val, ev, cv;
	logic           early;

	always_comb begin
		if (cfg.steps == 9'd0) begin
			n_eff = IW'(1);
		end else if (32'(cfg.steps) > 32'(MAX_STEPS)) begin
			n_eff = IW'(MAX_STEPS);
		end else begin
			n_eff = IW'(cfg.steps);
		end
		add_sum = {1'b0, su_q} + {1'b0, vd_q - sc_rsp.y};
		t_val   = add_sum[PW] ? '1 : add_sum[PW-1:0];
		early   = amer_q && (lvl_q != '0);
		ev      = payoff(1'b1, ep_q, strike_q);
		cv      = (early && (ev > sc_rsp.y)) ? ev : sc_rsp.y;
	end

	always_comb begin
		vm_we    = 1'b0;
		vm_waddr = b_q;
		vm_wdata = cv;
		vm_raddr = '0;
		pm_we    = 1'b0;
		pm_waddr = addr_q;
		pm_wdata = sc_rsp.y;
		pm_raddr = col_q + PAW'(b_q);
		sc_req   = '0;
		unique case (state_q)
			S_BFIRST: begin
				pm_we    = 1'b1;
				pm_waddr = '0;
				pm_wdata = spot_q;
			end
			S_BNEXT: begin
				if (i_q < n_q) begin
					sc_req = '{go: 1'b1, x: cur_q, f: cfg.down, sh30: 1'b1};
				end else if (a_q < n_q) begin
					sc_req = '{go: 1'b1, x: head_q, f: cfg.up, sh30: 1'b1};
				end
			end
			S_BWAIT: begin
				pm_we = sc_rsp.done;
			end
			S_TWR: begin
				vm_we    = 1'b1;
				vm_wdata = payoff(put_q, pm_rdata, strike_q);
			end
			S_IRD0: begin
				vm_raddr = b_q + IW'(1);
			end
			S_IRD1: begin
				sc_req = '{go: 1'b1, x: vu_q, f: cfg.prob, sh30: 1'b0};
			end
			S_IW1: begin
				sc_req = '{go: sc_rsp.done, x: vd_q, f: cfg.prob, sh30: 1'b0};
			end
			S_IW2: begin
				sc_req = '{go: sc_rsp.done, x: t_val, f: cfg.disc, sh30: 1'b0};
			end
			S_IW3: begin
				vm_we    = sc_rsp.done;
				vm_raddr = b_q + IW'(2);
				pm_raddr = col_q + PAW'(b_q) + PAW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						spot_q   <= spot_price;
						strike_q <= strike_price;
						n_q      <= n_eff;
						put_q    <= (cfg.kind == KIND_PUT_EU) || (cfg.kind == KIND_PUT_AM);
						amer_q   <= (cfg.kind == KIND_PUT_AM);
						sat_q    <= 1'b0;
						state_q  <= S_BFIRST;
					end
				end
				S_BFIRST: begin
					cur_q   <= spot_q;
					head_q  <= spot_q;
					a_q     <= '0;
					b_q     <= '0;
					i_q     <= '0;
					col_q   <= '0;
					addr_q  <= '0;
					state_q <= S_BNEXT;
				end
				S_BNEXT: begin
					if (i_q < n_q) begin
						b_q     <= b_q + IW'(1);
						i_q     <= i_q + IW'(1);
						addr_q  <= addr_q + PAW'(i_q) + PAW'(2);
						colst_q <= 1'b0;
						state_q <= S_BWAIT;
					end else if (a_q < n_q) begin
						a_q     <= a_q + IW'(1);
						b_q     <= '0;
						i_q     <= a_q + IW'(1);
						col_q   <= col_q + PAW'(a_q) + PAW'(1);
						addr_q  <= col_q + PAW'(a_q) + PAW'(1);
						colst_q <= 1'b1;
						state_q <= S_BWAIT;
					end else begin
						b_q     <= '0;
						state_q <= S_TRD;
					end
				end
				S_BWAIT: begin
					if (sc_rsp.done) begin
						cur_q <= sc_rsp.y;
						if (colst_q) begin
							head_q <= sc_rsp.y;
						end
						sat_q   <= sat_q | sc_rsp.ovf;
						state_q <= S_BNEXT;
					end
				end
				S_TRD: begin
					state_q <= S_TWR;
				end
				S_TWR: begin
					if (b_q == n_q) begin
						lvl_q   <= n_q;
						state_q <= S_ILVL;
					end else begin
						b_q     <= b_q + IW'(1);
						state_q <= S_TRD;
					end
				end
				S_ILVL: begin
					col_q   <= col_q - PAW'(lvl_q);
					lvl_q   <= lvl_q - IW'(1);
					b_q     <= '0;
					state_q <= S_IRD0;
				end
				S_IRD0: begin
					vu_q    <= vm_rdata;
					state_q <= S_IRD1;
				end
				S_IRD1: begin
					vd_q    <= vm_rdata;
					ep_q    <= pm_rdata;
					state_q <= S_IW1;
				end
				S_IW1: begin
					if (sc_rsp.done) begin
						su_q    <= sc_rsp.y;
						sat_q   <= sat_q | sc_rsp.ovf;
						state_q <= S_IW2;
					end
				end
				S_IW2: begin
					if (sc_rsp.done) begin
						sat_q   <= sat_q | sc_rsp.ovf | add_sum[PW];
						state_q <= S_IW3;
					end
				end
				S_IW3: begin
					if (sc_rsp.done) begin
						sat_q <= sat_q | sc_rsp.ovf;
						vu_q  <= vd_q;
						if (b_q == lvl_q) begin
							if (lvl_q == '0) begin
								res_q   <= cv;
								state_q <= S_FIN;
							end else begin
								state_q <= S_ILVL;
							end
						end else begin
							b_q     <= b_q + IW'(1);
							state_q <= S_IRD1;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						option_value_q <= res_q;
						saturated_q    <= sat_q;
						out_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign option_value = option_value_q;
	assign saturated    = saturated_q;

endmodule
